// ===== design/efop_pkg.sv =====
// Package with the shared types, codes and constants of the electronic fuse controller.
`default_nettype none
package efop_pkg;

	localparam int AdcBits  = 12;
	localparam int DtW      = 16;
	localparam int QualW    = 16;
	localparam int OcTimeW  = 17;
	localparam int TripW    = 16;
	localparam int CfgDataW = 16;

	typedef logic [1:0] opcode_t;
	localparam opcode_t OP_SAMPLE = 2'd0;
	localparam opcode_t OP_ENABLE = 2'd1;
	localparam opcode_t OP_RESET  = 2'd2;
	localparam opcode_t OP_STATUS = 2'd3;

	typedef logic [1:0] pwr_t;
	localparam pwr_t PWR_OFF   = 2'd0;
	localparam pwr_t PWR_ON    = 2'd1;
	localparam pwr_t PWR_FAULT = 2'd2;

	typedef logic [1:0] fault_t;
	localparam fault_t FC_NONE        = 2'd0;
	localparam fault_t FC_THERMAL     = 2'd1;
	localparam fault_t FC_SHORT       = 2'd2;
	localparam fault_t FC_OVERCURRENT = 2'd3;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_OC_THRESH    = 2'd0;
	localparam cfg_idx_t CFG_SHORT_THRESH = 2'd1;
	localparam cfg_idx_t CFG_QUALIFY      = 2'd2;

	localparam logic [AdcBits-1:0] OcThreshRst    = 12'd1986;
	localparam logic [AdcBits-1:0] ShortThreshRst = 12'd3723;
	localparam logic [QualW-1:0]   QualifyRst     = 16'd50;
	localparam logic [OcTimeW-1:0] OcTimeMax      = 17'h1FFFF;
	localparam logic [TripW-1:0]   TripMax        = 16'hFFFF;

	typedef struct packed {
		logic load;
		logic update;
		logic decide;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic sample_go;
		logic div_done;
		logic out_free;
	} ctrl_sts_t;

endpackage
`default_nettype wire

// ===== design/efop_if.sv =====
// Request and response channel interfaces of the electronic fuse controller.
`default_nettype none
interface efop_req_if;
	import efop_pkg::*;
	logic                 valid;
	logic                 ready;
	opcode_t              opcode;
	logic [AdcBits-1:0]   adc_code;
	logic [DtW-1:0]       elapsed_ms;
	logic                 over_temp;
	modport source (output valid, opcode, adc_code, elapsed_ms, over_temp, input ready);
	modport sink   (input valid, opcode, adc_code, elapsed_ms, over_temp, output ready);
endinterface

interface efop_rsp_if;
	import efop_pkg::*;
	logic                 valid;
	logic                 ready;
	pwr_t                 power_state;
	fault_t               fault_code;
	logic [AdcBits-1:0]   average_code;
	logic [OcTimeW-1:0]   overcurrent_time;
	logic [TripW-1:0]     trip_count;
	modport source (output valid, power_state, fault_code, average_code, overcurrent_time,
		trip_count, input ready);
	modport sink   (input valid, power_state, fault_code, average_code, overcurrent_time,
		trip_count, output ready);
endinterface
`default_nettype wire

// ===== design/efuse_overcurrent_protector_top.sv =====
// Top level of the electronic fuse overcurrent protection controller.
//
// Each request on req carries an opcode (sample, enable, reset fault, status read),
// an ADC code, the milliseconds since the last sample and a thermal flag. Every
// request produces exactly one status response on rsp, showing the fuse state after
// the request. The user must write thresholds and the qualification time on the cfg
// port only while no request is outstanding; the block itself does not enforce it.
// A sample taken while the fuse is on updates a WINDOW-entry ring and divides the
// running sum by the fill count in a one-bit-per-cycle divider before the decide
// and emit states; all other requests go from acceptance straight to those states.
// One request is handled at a time; the response register lets the next request be
// accepted while the previous response still waits. If rsp stalls, the block holds
// its finished response, still takes the next request and works it up to its own
// response, and then takes no further request until the held response is taken.
// Reset loads the default thresholds, clears the filter, the fault, the timers and
// the trip counter and leaves the fuse off.
`default_nettype none
module efuse_overcurrent_protector_top #(
	parameter int WINDOW = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  efop_pkg::cfg_idx_t            cfg_index,
	input  logic [efop_pkg::CfgDataW-1:0] cfg_data,
	efop_req_if.sink                      req,
	efop_rsp_if.source                    rsp
);
	import efop_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	efop_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.sts       (sts),
		.req_ready (req.ready),
		.cmd       (cmd)
	);

	efop_dp #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.req_opcode           (req.opcode),
		.req_adc_code         (req.adc_code),
		.req_elapsed_ms       (req.elapsed_ms),
		.req_over_temp        (req.over_temp),
		.rsp_ready            (rsp.ready),
		.cmd                  (cmd),
		.sts                  (sts),
		.rsp_valid            (rsp.valid),
		.rsp_power_state      (rsp.power_state),
		.rsp_fault_code       (rsp.fault_code),
		.rsp_average_code     (rsp.average_code),
		.rsp_overcurrent_time (rsp.overcurrent_time),
		.rsp_trip_count       (rsp.trip_count)
	);
endmodule
`default_nettype wire

// ===== design/efop_div.sv =====
// Restoring divider, one quotient bit per cycle, for the moving-average filter.
`default_nettype none
module efop_div #(
	parameter int SumW = 15,
	parameter int CntW = 4,
	parameter int QuoW = 12
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [SumW-1:0] dividend,
	input  logic [CntW-1:0] divisor,
	output logic [QuoW-1:0] quotient,
	output logic            done
);
	localparam int IterW = (SumW > 1) ? $clog2(SumW) : 1;

	logic [SumW-1:0]  quo_q;
	logic [CntW-1:0]  rem_q;
	logic [CntW-1:0]  div_q;
	logic [IterW-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [CntW:0]    trial;
	logic             take;
	logic [CntW:0]    diff;

	assign trial = {rem_q, quo_q[SumW-1]};
	assign take  = (trial >= {1'b0, div_q});
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= IterW'(SumW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SumW-2:0], take};
			rem_q <= take ? diff[CntW-1:0] : trial[CntW-1:0];
		end
	end

	assign quotient = quo_q[QuoW-1:0];
	assign done     = done_q;
endmodule
`default_nettype wire

// ===== design/efop_dp.sv =====
// Datapath: configuration, sample ring, running sum, fault logic and response register.
`default_nettype none
module efop_dp #(
	parameter int WINDOW = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  efop_pkg::cfg_idx_t              cfg_index,
	input  logic [efop_pkg::CfgDataW-1:0]   cfg_data,
	input  efop_pkg::opcode_t               req_opcode,
	input  logic [efop_pkg::AdcBits-1:0]    req_adc_code,
	input  logic [efop_pkg::DtW-1:0]        req_elapsed_ms,
	input  logic                            req_over_temp,
	input  logic                            rsp_ready,
	input  efop_pkg::ctrl_cmd_t             cmd,
	output efop_pkg::ctrl_sts_t             sts,
	output logic                            rsp_valid,
	output efop_pkg::pwr_t                  rsp_power_state,
	output efop_pkg::fault_t                rsp_fault_code,
	output logic [efop_pkg::AdcBits-1:0]    rsp_average_code,
	output logic [efop_pkg::OcTimeW-1:0]    rsp_overcurrent_time,
	output logic [efop_pkg::TripW-1:0]      rsp_trip_count
);
	import efop_pkg::*;

	localparam int PosW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CntW = $clog2(WINDOW + 1);
	localparam int SumW = AdcBits + ((WINDOW > 1) ? $clog2(WINDOW) : 0);

	logic [AdcBits-1:0] oc_thresh_q;
	logic [AdcBits-1:0] short_thresh_q;
	logic [QualW-1:0]   qualify_q;

	opcode_t            op_q;
	logic [AdcBits-1:0] code_q;
	logic [DtW-1:0]     dt_q;
	logic               thermal_q;

	logic [AdcBits-1:0] ring_mem [WINDOW];
	logic [AdcBits-1:0] rd_q;
	logic [PosW-1:0]    wp_q;
	logic [CntW-1:0]    fill_q;
	logic [SumW-1:0]    sum_q;

	pwr_t               state_q;
	fault_t             fault_q;
	logic [AdcBits-1:0] avg_q;
	logic [OcTimeW-1:0] oc_q;
	logic [TripW-1:0]   trip_q;
	logic               out_valid_q;

	logic [AdcBits-1:0] old_code;
	logic [SumW-1:0]    sum_next;
	logic [CntW-1:0]    fill_next;
	logic [PosW-1:0]    wp_next;
	logic [AdcBits-1:0] quotient;
	logic               div_done;

	logic [OcTimeW:0]   oc_sum;
	logic [OcTimeW-1:0] oc_sat;
	fault_t             fault_new;
	pwr_t               state_d;
	fault_t             fault_d;
	logic [AdcBits-1:0] avg_d;
	logic [OcTimeW-1:0] oc_d;
	logic [TripW-1:0]   trip_d;

	// An entry not yet written since reset reads as zero; the fill count tells which.
	assign old_code  = (fill_q == CntW'(WINDOW)) ? rd_q : '0;
	assign sum_next  = sum_q - SumW'(old_code) + SumW'(code_q);
	assign fill_next = (fill_q == CntW'(WINDOW)) ? fill_q : fill_q + 1'b1;
	assign wp_next   = (wp_q == PosW'(WINDOW - 1)) ? '0 : wp_q + 1'b1;

	efop_div #(
		.SumW (SumW),
		.CntW (CntW),
		.QuoW (AdcBits)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.update),
		.dividend (sum_next),
		.divisor  (fill_next),
		.quotient (quotient),
		.done     (div_done)
	);

	assign oc_sum = {1'b0, oc_q} + (OcTimeW + 1)'(dt_q);
	assign oc_sat = (oc_sum > {1'b0, OcTimeMax}) ? OcTimeMax : oc_sum[OcTimeW-1:0];

	always_comb begin
		state_d   = state_q;
		fault_d   = fault_q;
		avg_d     = avg_q;
		oc_d      = oc_q;
		trip_d    = trip_q;
		fault_new = FC_NONE;
		unique case (op_q)
			OP_SAMPLE: begin
				if (state_q == PWR_ON) begin
					avg_d = quotient;
					priority if (thermal_q) begin
						fault_new = FC_THERMAL;
					end else if (quotient >= short_thresh_q) begin
						fault_new = FC_SHORT;
					end else if (quotient >= oc_thresh_q) begin
						oc_d = oc_sat;
						if (oc_sat >= OcTimeW'(qualify_q)) begin
							fault_new = FC_OVERCURRENT;
						end
					end else begin
						oc_d = '0;
					end
				end
			end
			OP_ENABLE: begin
				if (fault_q == FC_NONE) begin
					state_d = PWR_ON;
				end
			end
			OP_RESET: begin
				state_d = PWR_OFF;
				fault_d = FC_NONE;
				oc_d    = '0;
			end
			OP_STATUS: begin
			end
		endcase
		if (fault_new != FC_NONE) begin
			fault_d = fault_new;
			state_d = PWR_FAULT;
			trip_d  = (trip_q == TripMax) ? trip_q : trip_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oc_thresh_q    <= OcThreshRst;
			short_thresh_q <= ShortThreshRst;
			qualify_q      <= QualifyRst;
			wp_q           <= '0;
			fill_q         <= '0;
			sum_q          <= '0;
			state_q        <= PWR_OFF;
			fault_q        <= FC_NONE;
			avg_q          <= '0;
			oc_q           <= '0;
			trip_q         <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_OC_THRESH:    oc_thresh_q    <= cfg_data[AdcBits-1:0];
					CFG_SHORT_THRESH: short_thresh_q <= cfg_data[AdcBits-1:0];
					CFG_QUALIFY:      qualify_q      <= cfg_data[QualW-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.update) begin
				wp_q   <= wp_next;
				fill_q <= fill_next;
				sum_q  <= sum_next;
			end
			if (cmd.decide) begin
				state_q <= state_d;
				fault_q <= fault_d;
				avg_q   <= avg_d;
				oc_q    <= oc_d;
				trip_q  <= trip_d;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= ring_mem[wp_q];
		if (cmd.update) begin
			ring_mem[wp_q] <= code_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= req_opcode;
			code_q    <= req_adc_code;
			dt_q      <= req_elapsed_ms;
			thermal_q <= req_over_temp;
		end
		if (cmd.emit) begin
			rsp_power_state      <= state_q;
			rsp_fault_code       <= fault_q;
			rsp_average_code     <= avg_q;
			rsp_overcurrent_time <= oc_q;
			rsp_trip_count       <= trip_q;
		end
	end

	assign sts.sample_go = (req_opcode == OP_SAMPLE) && (state_q == PWR_ON);
	assign sts.div_done  = div_done;
	assign sts.out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid     = out_valid_q;
endmodule
`default_nettype wire

// ===== design/efop_ctrl.sv =====
// Controller state machine that sequences each request through the datapath.
`default_nettype none
module efop_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  efop_pkg::ctrl_sts_t sts,
	output logic                req_ready,
	output efop_pkg::ctrl_cmd_t cmd
);
	import efop_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_UPDATE = 5'b00010,
		ST_DIVIDE = 5'b00100,
		ST_DECIDE = 5'b01000,
		ST_EMIT   = 5'b10000
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.sample_go ? ST_UPDATE : ST_DECIDE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (sts.div_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == ST_IDLE);
endmodule
`default_nettype wire

// ===== design/efop_checker.sv =====
// Port-level checker for the electronic fuse controller and its bind to the top level.
`default_nettype none
module efop_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input efop_pkg::pwr_t                 power_state,
	input efop_pkg::fault_t               fault_code,
	input logic [efop_pkg::AdcBits-1:0]   average_code,
	input logic [efop_pkg::OcTimeW-1:0]   overcurrent_time,
	input logic [efop_pkg::TripW-1:0]     trip_count
);
	import efop_pkg::*;

	// A faulted fuse always reports a cause, and a healthy one never does.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((power_state == PWR_FAULT) == (fault_code != FC_NONE)))
	else $error("fault code disagrees with power state");

	// Only one request is in flight at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
	else $error("request accepted while another is in flight");

	// A fuse that is off has no accumulated overcurrent time.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (power_state == PWR_OFF)) |-> (overcurrent_time == '0))
	else $error("overcurrent time held while the fuse is off");

	// A stalled response holds its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(power_state) &&
			$stable(fault_code) && $stable(average_code) &&
			$stable(overcurrent_time) && $stable(trip_count)))
	else $error("stalled response changed");
endmodule

bind efuse_overcurrent_protector_top efop_checker u_efop_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.power_state      (rsp.power_state),
	.fault_code       (rsp.fault_code),
	.average_code     (rsp.average_code),
	.overcurrent_time (rsp.overcurrent_time),
	.trip_count       (rsp.trip_count)
);
`default_nettype wire

// ===== tb/efuse_overcurrent_protector_checker.sv =====
// Checker that predicts and compares every status response of the electronic fuse controller.
`timescale 1ns / 1ps
module efuse_overcurrent_protector_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  efop_pkg::cfg_idx_t            cfg_index,
	input  logic [efop_pkg::CfgDataW-1:0] cfg_data,
	efop_req_if                           req,
	efop_rsp_if                           rsp,
	output int                            outstanding,
	output int                            fail_count
);
	import efop_pkg::*;

	localparam int Depth = 8;
	localparam int PosW  = $clog2(Depth);

	typedef struct packed {
		pwr_t               power;
		fault_t             fault;
		logic [AdcBits-1:0] average;
		logic [OcTimeW-1:0] oc_ms;
		logic [TripW-1:0]   trips;
	} fuse_status_t;

	logic [AdcBits-1:0] oc_limit;
	logic [AdcBits-1:0] short_limit;
	logic [QualW-1:0]   qualify_time;

	logic [AdcBits-1:0] ring [Depth];
	logic [PosW-1:0]    wr_pos;
	logic [3:0]         filled;
	logic [14:0]        ring_total;
	pwr_t               power;
	fault_t             fault;
	logic [AdcBits-1:0] average;
	logic [OcTimeW-1:0] oc_ms;
	logic [TripW-1:0]   trips;

	fuse_status_t status_q [$];
	fuse_status_t want;
	int           mismatches = 0;

	assign fail_count = mismatches;

	task automatic report(string what, longint unsigned got, longint unsigned wanted);
		mismatches++;
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, wanted);
	endtask

	function automatic fuse_status_t fuse_step(opcode_t op, logic [AdcBits-1:0] code,
		logic [DtW-1:0] dt, logic hot);
		fault_t       trip;
		logic [17:0]  sum_ms;
		fuse_status_t s;
		trip = FC_NONE;
		case (op)
			OP_SAMPLE: begin
				if (power == PWR_ON) begin
					ring_total = ring_total - ring[wr_pos] + code;
					ring[wr_pos] = code;
					wr_pos = wr_pos + 1'b1;
					if (filled < Depth)
						filled = filled + 1'b1;
					average = 12'(ring_total / filled);
					if (hot) begin
						trip = FC_THERMAL;
					end else if (average >= short_limit) begin
						trip = FC_SHORT;
					end else if (average >= oc_limit) begin
						sum_ms = {1'b0, oc_ms} + dt;
						oc_ms = (sum_ms > OcTimeMax) ? OcTimeMax : sum_ms[OcTimeW-1:0];
						if (oc_ms >= qualify_time)
							trip = FC_OVERCURRENT;
					end else begin
						oc_ms = '0;
					end
					if (trip != FC_NONE) begin
						fault = trip;
						power = PWR_FAULT;
						if (trips != TripMax)
							trips = trips + 1'b1;
					end
				end
			end
			OP_ENABLE: begin
				if (fault == FC_NONE)
					power = PWR_ON;
			end
			OP_RESET: begin
				power = PWR_OFF;
				fault = FC_NONE;
				oc_ms = '0;
			end
			default: begin
			end
		endcase
		s = '{power, fault, average, oc_ms, trips};
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oc_limit = OcThreshRst;
			short_limit = ShortThreshRst;
			qualify_time = QualifyRst;
			for (int k = 0; k < Depth; k++)
				ring[k] = '0;
			wr_pos = '0;
			filled = '0;
			ring_total = '0;
			power = PWR_OFF;
			fault = FC_NONE;
			average = '0;
			oc_ms = '0;
			trips = '0;
			status_q.delete();
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (status_q.size() == 0) begin
					report("response with no request waiting", 1, 0);
				end else begin
					want = status_q.pop_front();
					if (rsp.power_state !== want.power)
						report("power_state", rsp.power_state, want.power);
					if (rsp.fault_code !== want.fault)
						report("fault_code", rsp.fault_code, want.fault);
					if (rsp.average_code !== want.average)
						report("average_code", rsp.average_code, want.average);
					if (rsp.overcurrent_time !== want.oc_ms)
						report("overcurrent_time", rsp.overcurrent_time, want.oc_ms);
					if (rsp.trip_count !== want.trips)
						report("trip_count", rsp.trip_count, want.trips);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_OC_THRESH:    oc_limit = cfg_data[AdcBits-1:0];
					CFG_SHORT_THRESH: short_limit = cfg_data[AdcBits-1:0];
					CFG_QUALIFY:      qualify_time = cfg_data[QualW-1:0];
					default: begin
					end
				endcase
			end
			if (req.valid && req.ready)
				status_q.push_back(fuse_step(req.opcode, req.adc_code, req.elapsed_ms,
					req.over_temp));
			outstanding <= status_q.size();
		end
	end

endmodule

// ===== tb/efuse_overcurrent_protector_top_test.sv =====
// Top of the testbench: clock, reset, request and limit stimulus, and the final verdict.
`timescale 1ns / 1ps
module efuse_overcurrent_protector_top_test;
	import efop_pkg::*;

	localparam cfg_idx_t CFG_SPARE   = 2'd3;
	localparam int       DrainCycles = 40;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	cfg_idx_t            cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic                idle_on;
	int                  outstanding;
	int                  fail_count;
	logic [AdcBits-1:0]  oc_level;
	logic [AdcBits-1:0]  short_level;

	efop_req_if req ();
	efop_rsp_if rsp ();

	efuse_overcurrent_protector_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.rsp       (rsp)
	);

	efuse_overcurrent_protector_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req         (req),
		.rsp         (rsp),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= !(idle_on && $urandom_range(99) < 31);
		end
	end

	task automatic send(opcode_t op, logic [AdcBits-1:0] code, logic [DtW-1:0] dt, logic hot);
		while (idle_on && $urandom_range(99) < 31) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= op;
		req.adc_code <= code;
		req.elapsed_ms <= dt;
		req.over_temp <= hot;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	task automatic send_random();
		int unsigned        pick;
		opcode_t            op;
		logic [AdcBits-1:0] code;
		logic [DtW-1:0]     dt;
		pick = $urandom_range(99);
		if (pick < 58)
			op = OP_SAMPLE;
		else if (pick < 76)
			op = OP_ENABLE;
		else if (pick < 90)
			op = OP_RESET;
		else
			op = OP_STATUS;
		case ($urandom_range(3))
			0: code = 12'($urandom);
			1: code = 12'(oc_level + $urandom_range(40) - 20);
			2: code = 12'(short_level + $urandom_range(40) - 20);
			default: code = 12'($urandom_range(oc_level));
		endcase
		dt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(40));
		send(op, code, dt, $urandom_range(24) == 0);
	endtask

	// Holds off new requests until every outstanding response has been taken.
	task automatic settle();
		req.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic set_limits(logic [AdcBits-1:0] oc, logic [AdcBits-1:0] sc, logic [QualW-1:0] q);
		oc_level = oc;
		short_level = sc;
		cfg_we <= 1'b1;
		cfg_index <= CFG_OC_THRESH;
		cfg_data <= {4'($urandom), oc};
		@(posedge clk);
		cfg_index <= CFG_SHORT_THRESH;
		cfg_data <= {4'($urandom), sc};
		@(posedge clk);
		cfg_index <= CFG_QUALIFY;
		cfg_data <= q;
		@(posedge clk);
		cfg_index <= CFG_SPARE;
		cfg_data <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_OC_THRESH;
		cfg_data <= '0;
		req.valid <= 1'b0;
		req.opcode <= OP_STATUS;
		req.adc_code <= '0;
		req.elapsed_ms <= '0;
		req.over_temp <= 1'b0;
		idle_on <= 1'b1;
		oc_level = OcThreshRst;
		short_level = ShortThreshRst;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		send(OP_STATUS, 12'd0, 16'd0, 1'b0);
		send(OP_SAMPLE, 12'd4095, 16'd65535, 1'b1);
		send(OP_RESET, 12'd0, 16'd0, 1'b0);
		send(OP_ENABLE, 12'd0, 16'd0, 1'b0);
		send(OP_ENABLE, 12'd4095, 16'd65535, 1'b1);
		send(OP_SAMPLE, 12'd0, 16'd0, 1'b0);
		send(OP_SAMPLE, 12'd4095, 16'd30, 1'b0);
		send(OP_STATUS, 12'd4095, 16'd65535, 1'b1);
		send(OP_SAMPLE, 12'd4095, 16'd65535, 1'b0);
		send(OP_ENABLE, 12'd0, 16'd0, 1'b0);
		send(OP_SAMPLE, 12'd4095, 16'd0, 1'b0);
		send(OP_RESET, 12'd4095, 16'd65535, 1'b1);
		send(OP_ENABLE, 12'd0, 16'd0, 1'b0);
		send(OP_SAMPLE, 12'd4095, 16'd0, 1'b1);
		send(OP_RESET, 12'd0, 16'd0, 1'b0);
		send(OP_ENABLE, 12'd0, 16'd0, 1'b0);
		repeat (5)
			send(OP_SAMPLE, 12'd4095, 16'd0, 1'b0);
		send(OP_STATUS, 12'd0, 16'd0, 1'b0);
		repeat (100)
			send_random();

		settle();
		set_limits(12'd0, 12'd4095, 16'd65535);
		repeat (90)
			send_random();

		settle();
		set_limits(12'd4095, 12'd0, 16'd0);
		repeat (60)
			send_random();

		settle();
		idle_on <= 1'b0;
		set_limits(12'($urandom_range(100, 2000)), 12'($urandom_range(2100, 4000)),
			16'($urandom_range(60)));
		repeat (110)
			send_random();

		settle();
		idle_on <= 1'b1;
		set_limits(OcThreshRst, ShortThreshRst, QualifyRst);
		repeat (90)
			send_random();

		settle();
		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/efop_pkg.sv
design/efop_if.sv
design/efop_div.sv
design/efop_dp.sv
design/efop_ctrl.sv
design/efuse_overcurrent_protector_top.sv
design/efop_checker.sv
tb/efuse_overcurrent_protector_checker.sv
tb/efuse_overcurrent_protector_top_test.sv
